[src/rrts_pkg.sv]
// Shared types and constants of the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

   localparam int CMD_W       = 2;
   localparam int TASK_SLOT_W = 6;
   localparam int SELECTOR_W  = 16;
   localparam int STATUS_W    = 2;
   localparam int FIRST_DESC_W = 13;

   // Selector is the descriptor index times eight.
   localparam int SEL_SHIFT = 3;

   // A tick only switches when at least this many run-list entries exist.
   localparam int MIN_SWITCH_TASKS = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CMD_W-1:0]        cmd_type;
   typedef logic [TASK_SLOT_W-1:0]  task_slot_type;
   typedef logic [SELECTOR_W-1:0]   selector_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [FIRST_DESC_W-1:0] first_desc_type;

   localparam cmd_type CMD_ALLOC  = 2'd0;
   localparam cmd_type CMD_RUN    = 2'd1;
   localparam cmd_type CMD_TICK   = 2'd2;
   localparam cmd_type CMD_UNUSED = 2'd3;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_FREE   = 2'd1;
   localparam status_type STATUS_NO_SWITCH = 2'd2;
   localparam status_type STATUS_LIST_FULL = 2'd3;

   localparam first_desc_type FIRST_DESC_RESET = 13'd3;

   // Register index of first_descriptor within the register map.
   localparam logic CSR_IDX_FIRST_DESC = 1'b0;

endpackage

`default_nettype wire

[src/rrts_if.sv]
// Request and response channel interfaces of the round-robin task scheduler.
`default_nettype none

interface rrts_req_if import rrts_pkg::*; ();
   logic          valid;
   logic          ready;
   cmd_type       cmd;
   task_slot_type task_slot;

   modport source (output valid, output cmd, output task_slot, input ready);
   modport sink   (input valid, input cmd, input task_slot, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
   logic          valid;
   logic          ready;
   task_slot_type result_slot;
   selector_type  selector;
   status_type    status;

   modport source (output valid, output result_slot, output selector, output status,
                   input ready);
   modport sink   (input valid, input result_slot, input selector, input status,
                   output ready);
endinterface

`default_nettype wire

[src/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler: slot table, run list and sequencer.
`default_nettype none

// The scheduler keeps a table of MAX_SLOTS task slots and a run list, and
// serves one command transaction at a time. After reset it makes a clearing
// pass through the slot table (slot 0 ends up active, all others free,
// run-list entry 0 holds slot 0); no command is accepted during that pass,
// while register writes are taken as usual. An allocate command walks the
// slot table through its single read port, one slot per cycle. A tick
// passes through an extra step for the registered read of the run-list
// memory. A response that still waits in the output register holds the
// sequencer in its last step until it is taken. A further command is
// accepted as soon as the sequencer is back to idle, even while the
// previous response transaction still waits in the output register.
// Every command gives exactly one response. The selector is
// (first_descriptor + result slot) * 8 modulo 2^16, and it reads as zero when
// allocation finds no free slot or the command code is unused. The run list
// saturates at MAX_SLOTS entries and answers a run command for a slot within
// range with status "run list full" from then on.
module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   rrts_req_if.sink               req_chan,
   rrts_rsp_if.source             rsp_chan,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire [CSR_ADDR_W-1:0]   paddr,
   input  wire [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   // Slot index width, run-count width, and a width that holds any reported slot.
   localparam int SLOT_W = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W  = (SLOT_W > TASK_SLOT_W) ? SLOT_W : TASK_SLOT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_SLOTS);
   localparam logic [CNT_W-1:0]  SWITCH_COUNT = CNT_W'(MIN_SWITCH_TASKS);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_LIST  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic              issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]  run_count_ff, run_count_in;
   logic [SLOT_W-1:0] current_pos_ff, current_pos_in;
   first_desc_type    first_desc_ff, first_desc_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Result staging; payload only.
   logic [IDX_W-1:0]  res_slot_ff, res_slot_in;
   status_type        res_status_ff, res_status_in;
   logic              sel_en_ff, sel_en_in;
   logic              from_list_ff, from_list_in;
   task_slot_type     rsp_slot_ff, rsp_slot_in;
   selector_type      rsp_sel_ff, rsp_sel_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Slot table holds one busy bit per slot (allocated or active).
   logic              busy_mem [MAX_SLOTS];
   logic              busy_rd_ff;
   logic              busy_we;
   logic [SLOT_W-1:0] busy_waddr;
   logic              busy_wdata;

   logic [TASK_SLOT_W-1:0] list_mem [MAX_SLOTS];
   logic [TASK_SLOT_W-1:0] list_rd_ff;
   logic                   list_we;
   logic [SLOT_W-1:0]      list_waddr;
   task_slot_type          list_wdata;

   logic              req_fire;
   logic              rsp_free;
   logic              run_beyond;
   logic              run_full;
   logic [CNT_W-1:0]  pos_inc;
   logic [IDX_W-1:0]  out_slot;
   first_desc_type    desc_sum;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign run_beyond = (32'(req_chan.task_slot) >= MAX_SLOTS);
   assign run_full   = (run_count_ff >= FULL_COUNT);
   assign pos_inc    = CNT_W'(current_pos_ff) + CNT_W'(1);

   // A tick result comes from the run-list read register, everything else
   // from the staged slot.
   assign out_slot = from_list_ff ? IDX_W'(list_rd_ff) : res_slot_ff;
   assign desc_sum = first_desc_ff + FIRST_DESC_W'(out_slot);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_slot = rsp_slot_ff;
   assign rsp_chan.selector    = rsp_sel_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // Configuration port: only register index 0 exists; other indexes are ignored.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_FIRST_DESC) ? CSR_DATA_W'(first_desc_ff)
                                                    : '0;

   always_comb begin
      first_desc_in = first_desc_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_FIRST_DESC)) begin
         first_desc_in = pwdata[FIRST_DESC_W-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      scan_in        = scan_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = scan_ff;
      run_count_in   = run_count_ff;
      current_pos_in = current_pos_ff;
      res_slot_in    = res_slot_ff;
      res_status_in  = res_status_ff;
      sel_en_in      = sel_en_ff;
      from_list_in   = from_list_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_sel_in     = rsp_sel_ff;
      rsp_status_in  = rsp_status_ff;
      busy_we        = 1'b0;
      busy_waddr     = clr_ff;
      busy_wdata     = 1'b0;
      list_we        = 1'b0;
      list_waddr     = clr_ff;
      list_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Slot 0 comes out active; every other slot free.
            busy_we    = 1'b1;
            busy_wdata = (clr_ff == '0);
            list_we    = 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               from_list_in = 1'b0;
               sel_en_in    = 1'b1;
               res_status_in = STATUS_OK;
               res_slot_in  = IDX_W'(req_chan.task_slot);
               unique case (req_chan.cmd)
                  CMD_ALLOC: begin
                     scan_in  = '0;
                     issue_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  CMD_RUN: begin
                     state_in = ST_DONE;
                     if (run_beyond) begin
                        res_status_in = STATUS_OK;
                     end else if (run_full) begin
                        res_status_in = STATUS_LIST_FULL;
                     end else begin
                        busy_we      = 1'b1;
                        busy_waddr   = SLOT_W'(req_chan.task_slot);
                        busy_wdata   = 1'b1;
                        list_we      = 1'b1;
                        list_waddr   = run_count_ff[SLOT_W-1:0];
                        list_wdata   = req_chan.task_slot;
                        run_count_in = run_count_ff + CNT_W'(1);
                     end
                  end
                  CMD_TICK: begin
                     from_list_in = 1'b1;
                     state_in     = ST_LIST;
                     if (run_count_ff < SWITCH_COUNT) begin
                        res_status_in = STATUS_NO_SWITCH;
                     end else if (pos_inc >= run_count_ff) begin
                        current_pos_in = '0;
                     end else begin
                        current_pos_in = SLOT_W'(pos_inc);
                     end
                  end
                  CMD_UNUSED: begin
                     res_slot_in   = '0;
                     sel_en_in     = 1'b0;
                     res_status_in = STATUS_NO_SWITCH;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // One slot read is issued per cycle; its busy bit is checked in
            // the following cycle.
            chk_vld_in = issue_ff;
            chk_idx_in = scan_ff;
            if (issue_ff) begin
               if (scan_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + SLOT_W'(1);
               end
            end
            if (chk_vld_ff && !busy_rd_ff) begin
               busy_we       = 1'b1;
               busy_waddr    = chk_idx_ff;
               busy_wdata    = 1'b1;
               res_slot_in   = IDX_W'(chk_idx_ff);
               res_status_in = STATUS_OK;
               sel_en_in     = 1'b1;
               issue_in      = 1'b0;
               chk_vld_in    = 1'b0;
               state_in      = ST_DONE;
            end else if (chk_vld_ff && (chk_idx_ff == LAST_SLOT)) begin
               res_slot_in   = '0;
               res_status_in = STATUS_NO_FREE;
               sel_en_in     = 1'b0;
               issue_in      = 1'b0;
               chk_vld_in    = 1'b0;
               state_in      = ST_DONE;
            end
         end

         ST_LIST: begin
            // The run-list read register picks up the entry at the new position.
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = TASK_SLOT_W'(out_slot);
               rsp_sel_in    = sel_en_ff ? {desc_sum, SEL_SHIFT'(0)} : '0;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         issue_ff       <= 1'b0;
         chk_vld_ff     <= 1'b0;
         run_count_ff   <= CNT_W'(1);
         current_pos_ff <= '0;
         first_desc_ff  <= FIRST_DESC_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         issue_ff       <= issue_in;
         chk_vld_ff     <= chk_vld_in;
         run_count_ff   <= run_count_in;
         current_pos_ff <= current_pos_in;
         first_desc_ff  <= first_desc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      sel_en_ff     <= sel_en_in;
      from_list_ff  <= from_list_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Slot table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (busy_we) begin
         busy_mem[busy_waddr] <= busy_wdata;
      end
      busy_rd_ff <= busy_mem[scan_ff];
   end

   // Run-list memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wdata;
      end
      list_rd_ff <= list_mem[current_pos_ff];
   end

   // The run list never grows past the slot count.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= FULL_COUNT)
      else $error("run count exceeds the slot count");

   // The current position always points at a filled run-list entry.
   a_pos_in_list: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(current_pos_ff) < run_count_ff)
      else $error("current position beyond the run list");

   // The sequencer is not ready again in the cycle after a command transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command accepted back to back");

   // A failed allocation never carries a selector.
   a_no_free_sel: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == STATUS_NO_FREE)) |-> (rsp_chan.selector == '0))
      else $error("selector given with no free slot");

endmodule

`default_nettype wire

[test/tb_round_robin_task_scheduler.sv]
// Self-checking testbench for the round-robin task scheduler.
`timescale 1ns / 100ps

// Commands go in on the request channel and every one of them produces exactly
// one response transaction. A scoreboard object keeps its own copy of the slot
// table, the run list and the first_descriptor register. It works out the
// answer of each accepted command and keeps a queue of answers due. Responses
// are checked in order, field by field, against that queue.
module tb_round_robin_task_scheduler import rrts_pkg::*; ();

   localparam int NUM_SLOTS      = 64;
   localparam int PHASE_ITEMS    = 400;
   localparam int NUM_PHASES     = 5;
   // The slowest command is an allocate that scans the whole table. The limit
   // leaves room for that scan, the longest stall on both sides and the
   // clearing pass after reset, several times over.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = NUM_SLOTS + 16;

   typedef enum logic [1:0] {SLOT_FREE, SLOT_USED, SLOT_ACTIVE} slot_mode_type;

   typedef struct packed {
      task_slot_type slot;
      selector_type  sel;
      status_type    status;
   } sched_answer_type;

   class dispatch_scoreboard;
      first_desc_type   first_desc;
      slot_mode_type    slot_mode [NUM_SLOTS];
      task_slot_type    run_queue [NUM_SLOTS];
      int               run_len;
      int               run_pos;
      sched_answer_type answers_due [$];
      int               mismatches;

      function new();
         first_desc = FIRST_DESC_RESET;
         foreach (slot_mode[i]) begin
            slot_mode[i] = SLOT_FREE;
            run_queue[i] = '0;
         end
         slot_mode[0] = SLOT_ACTIVE;
         run_len      = 1;
         run_pos      = 0;
         mismatches   = 0;
      endfunction

      function selector_type selector_of(int unsigned slot);
         int unsigned desc_index;
         desc_index = first_desc + slot;
         return selector_type'(desc_index << SEL_SHIFT);
      endfunction

      // Applies one command to the local copy of the scheduler state and
      // returns the response it must produce.
      function sched_answer_type predict(cmd_type cmd, task_slot_type req_slot);
         sched_answer_type ans;
         int               hit;
         ans = '{slot: '0, sel: '0, status: STATUS_NO_SWITCH};
         case (cmd)
            CMD_ALLOC: begin
               hit = -1;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (hit < 0 && slot_mode[i] == SLOT_FREE) hit = i;
               if (hit < 0) begin
                  ans.status = STATUS_NO_FREE;
               end else begin
                  slot_mode[hit] = SLOT_USED;
                  ans.slot       = task_slot_type'(hit);
                  ans.sel        = selector_of(hit);
                  ans.status     = STATUS_OK;
               end
            end
            CMD_RUN: begin
               ans.slot   = req_slot;
               ans.sel    = selector_of(req_slot);
               ans.status = STATUS_OK;
               if (int'(req_slot) >= NUM_SLOTS) begin
                  ans.status = STATUS_OK;
               end else if (run_len >= NUM_SLOTS) begin
                  ans.status = STATUS_LIST_FULL;
               end else begin
                  slot_mode[req_slot] = SLOT_ACTIVE;
                  run_queue[run_len]  = req_slot;
                  run_len++;
               end
            end
            CMD_TICK: begin
               if (run_pos >= NUM_SLOTS) run_pos = 0;
               if (run_len >= MIN_SWITCH_TASKS) begin
                  run_pos++;
                  if (run_pos >= run_len || run_pos >= NUM_SLOTS) run_pos = 0;
                  ans.status = STATUS_OK;
               end else begin
                  ans.status = STATUS_NO_SWITCH;
               end
               ans.slot = run_queue[run_pos];
               ans.sel  = selector_of(run_queue[run_pos]);
            end
            default: begin
            end
         endcase
         return ans;
      endfunction

      task report(string what);
         mismatches++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      function void note_command(cmd_type cmd, task_slot_type req_slot);
         answers_due.push_back(predict(cmd, req_slot));
      endfunction

      task check_answer(task_slot_type slot, selector_type sel, status_type status);
         sched_answer_type due;
         if (answers_due.size() == 0) begin
            report($sformatf("response slot=%0d sel=%h status=%0d with none due",
                             slot, sel, status));
         end else begin
            due = answers_due.pop_front();
            if (slot !== due.slot)
               report($sformatf("result_slot %0d, expected %0d", slot, due.slot));
            if (sel !== due.sel)
               report($sformatf("selector %h, expected %h", sel, due.sel));
            if (status !== due.status)
               report($sformatf("status %0d, expected %0d", status, due.status));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shared between the two sides: when low, neither side inserts gaps.
   logic                  idle_on;
   int                    quiet_cycles;
   dispatch_scoreboard    board;

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   round_robin_task_scheduler #(
      .MAX_SLOTS (NUM_SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Presents one command and holds it until the block takes it. A random gap
   // may come first. Valid is only lowered for such a gap, so back-to-back
   // commands keep it high across the accepting edge.
   task automatic send_command(cmd_type cmd, task_slot_type slot);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.task_slot <= slot;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Mostly ticks, so that the run list rotates a great deal. Allocate and run
   // commands are rare enough that the table and the run list fill up around
   // the middle of the run, which leaves plenty of traffic on both sides of
   // the no-free-slot and list-full cases.
   task automatic send_random_command();
      int unsigned pick;
      cmd_type     cmd;
      pick = $urandom_range(0, 99);
      if (pick < 5)       cmd = CMD_ALLOC;
      else if (pick < 10) cmd = CMD_RUN;
      else if (pick < 95) cmd = CMD_TICK;
      else                cmd = CMD_UNUSED;
      send_command(cmd, task_slot_type'($urandom_range(0, NUM_SLOTS - 1)));
   endtask

   // Register write in a setup step and an access step. The unused upper data bits carry random values,
   // which the register must drop.
   task automatic write_first_desc(first_desc_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_FIRST_DESC);
      pwdata  <= {(CSR_DATA_W - FIRST_DESC_W)'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      board.first_desc = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // The first edge lets the last accepted command reach the queue of answers
   // due. After that, wait until every response has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (board.answers_due.size() != 0) @(posedge clock);
   endtask

   // Response side: ready drops for random bursts while idling is allowed.
   initial begin : rsp_backpressure
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    = $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Observes both channels and the register port at each edge. The same
   // process runs the watchdog, which counts cycles in which nothing at all
   // is accepted.
   always @(posedge clock) begin : observer
      logic took_req;
      logic took_rsp;
      logic took_csr;
      took_req = !reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
      took_rsp = !reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1;
      took_csr = psel && penable && pwrite && pready === 1'b1;
      if (took_req) board.note_command(req_bus.cmd, req_bus.task_slot);
      if (took_rsp) board.check_answer(rsp_bus.result_slot, rsp_bus.selector,
                                       rsp_bus.status);
      if (took_req || took_rsp || took_csr) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      first_desc_type desc_value;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_ALLOC;
      req_bus.task_slot = '0;
      idle_on           = 1'b1;
      quiet_cycles      = 0;
      board             = new();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with first_descriptor still at its reset value. With
      // only slot 0 on the run list a tick must not switch.
      send_command(CMD_TICK, '0);
      send_command(CMD_UNUSED, '1);
      // Two allocations take the lowest free slots; task_slot is ignored.
      send_command(CMD_ALLOC, '1);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_TICK, '1);
      // Run an allocated slot, a slot that is still free, and the slot that
      // is already active, which then sits on the list twice.
      send_command(CMD_RUN, task_slot_type'(2));
      send_command(CMD_RUN, '1);
      send_command(CMD_RUN, '0);
      // Enough ticks to wrap past the end of a four-entry list.
      repeat (6) send_command(CMD_TICK, task_slot_type'($urandom));
      // Slots 0 to 2 are taken, so allocation continues at slot 3.
      send_command(CMD_ALLOC, task_slot_type'($urandom));
      send_command(CMD_RUN, task_slot_type'(2));
      repeat (3) send_command(CMD_TICK, task_slot_type'($urandom));
      send_command(CMD_UNUSED, task_slot_type'($urandom));

      // Random part in phases, each with its own first_descriptor. The first
      // phase keeps the reset value; later ones take both extremes and a
      // random value. Writes only happen once the block has gone quiet.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            req_bus.valid <= 1'b0;
            wait_drained();
            case (phase)
               1:       desc_value = '0;
               2:       desc_value = '1;
               3:       desc_value = first_desc_type'($urandom);
               default: desc_value = '1;
            endcase
            write_first_desc(desc_value);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // The last phase runs at full rate; earlier ones have stretches
            // without gaps between stretches with random gaps.
            idle_on = (phase < NUM_PHASES - 1) && (n % 200 >= 60);
            send_random_command();
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
